/* sv/cobf_pkg.sv */
package cobf_pkg;

  // Default number of cascaded stages.
  localparam int MAX_STAGES_DEF = 8;

  // Field and word widths.
  localparam int SAMPLE_W   = 24;
  localparam int DATA_W     = 32;
  localparam int POLE_W     = 16;
  localparam int MODE_W     = 2;
  localparam int COUNT_W    = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int GUARD_W    = 8;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_MODE        = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STAGE_COUNT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_UPPER_POLE  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LOWER_POLE  = 2'd3;

  // Mode codes; bit one set selects band operation.
  localparam logic [MODE_W-1:0] MODE_LOWPASS  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_HIGHPASS = 2'd1;
  localparam logic [MODE_W-1:0] MODE_BAND     = 2'd2;

  // Register values after reset.
  localparam logic [MODE_W-1:0]  MODE_RST        = MODE_BAND;
  localparam logic [COUNT_W-1:0] STAGE_COUNT_RST = 4'd1;
  localparam logic [POLE_W-1:0]  POLE_RST        = 16'd0;

  // Access controls for one stage store.
  typedef struct packed {
    logic rd;
    logic wr;
    logic clr;
  } store_ctrl_t;

endpackage

/* sv/cascaded_one_pole_band_filter.sv */
// Each input transaction takes, per stage, a store read, a multiply and an accumulate
// step (a second multiply and accumulate in band mode) over N stages, N being the stage
// count clamped to MAX_STAGES, then a finish step. No new sample is taken until the last
// one is through: one shared multiplier steps through the stages and the
// read-modify-write of the stage stores. Reset clears both stores, the output valid flag and
// the sequencer, and loads the register defaults: band mode, one stage, both poles zero.
module cascaded_one_pole_band_filter import cobf_pkg::*; #(
  parameter int MAX_STAGES = MAX_STAGES_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic signed [SAMPLE_W-1:0]   sample_in_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic signed [SAMPLE_W-1:0]   sample_out_o,
  input  logic                         cfg_we_i,
  input  logic [CFG_IDX_W-1:0]         cfg_index_i,
  input  logic [CFG_DATA_W-1:0]        cfg_wdata_i
);

  localparam int AddrW  = (MAX_STAGES > 1) ? $clog2(MAX_STAGES) : 1;
  localparam int CountW = $clog2(MAX_STAGES + 1);

  // Sequencer states.
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_READ = 3'd1;
  localparam logic [2:0] S_MUL  = 3'd2;
  localparam logic [2:0] S_ACC  = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;

  // Which pole a stage is working on.
  localparam logic PASS_LOWER = 1'b0;
  localparam logic PASS_UPPER = 1'b1;

  logic [MODE_W-1:0]        mode_q;
  logic [COUNT_W-1:0]       stage_count_q;
  logic [POLE_W-1:0]        upper_pole_q;
  logic [POLE_W-1:0]        lower_pole_q;

  logic [2:0]               state_q;
  logic                     pass_q;
  logic                     band_q;
  logic                     high_q;
  logic [CountW-1:0]        k_q;
  logic [CountW-1:0]        n_q;
  logic [CountW-1:0]        n_eff;
  logic [CountW-1:0]        k_next;
  logic signed [DATA_W-1:0] v_q;
  logic                     out_valid_q;
  logic signed [SAMPLE_W-1:0] sample_out_q;

  logic                     in_accept;
  logic                     out_free;
  logic                     mode_band;
  logic                     mode_high;
  logic                     cfg_clr;
  store_ctrl_t              lower_ctrl;
  store_ctrl_t              upper_ctrl;
  logic [AddrW-1:0]         addr;
  logic signed [DATA_W-1:0] lower_rdata;
  logic signed [DATA_W-1:0] upper_rdata;
  logic signed [DATA_W-1:0] s_sel;
  logic [POLE_W-1:0]        pole_sel;
  logic signed [DATA_W-1:0] s_new;
  logic signed [DATA_W:0]   hp_diff;
  logic signed [DATA_W-1:0] hp_sat;
  logic signed [DATA_W:0]   rounded;
  logic signed [SAMPLE_W:0] y_wide;
  logic signed [SAMPLE_W-1:0] y_sat;

  // Handshake terms.
  assign in_stall_o  = (state_q != S_IDLE);
  assign in_accept   = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign sample_out_o = sample_out_q;

  // Mode decode: bit one wins, so the unused code acts as band mode.
  assign mode_band = mode_q[1];
  assign mode_high = !mode_q[1] && mode_q[0];

  // Stage count clamped to the store depth.
  assign n_eff = (32'(stage_count_q) > 32'(MAX_STAGES)) ? CountW'(MAX_STAGES)
                                                        : CountW'(stage_count_q);
  assign k_next = k_q + 1'b1;
  assign addr   = k_q[AddrW-1:0];

  // Every register write clears both stores.
  assign cfg_clr = cfg_we_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q        <= MODE_RST;
      stage_count_q <= STAGE_COUNT_RST;
      upper_pole_q  <= POLE_RST;
      lower_pole_q  <= POLE_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_MODE:        mode_q        <= cfg_wdata_i[MODE_W-1:0];
        CFG_STAGE_COUNT: stage_count_q <= cfg_wdata_i[COUNT_W-1:0];
        CFG_UPPER_POLE:  upper_pole_q  <= cfg_wdata_i[POLE_W-1:0];
        CFG_LOWER_POLE:  lower_pole_q  <= cfg_wdata_i[POLE_W-1:0];
        default:         mode_q        <= mode_q;
      endcase
    end
  end

  // Store controls: both stores are read together, each written on its own pass.
  always_comb begin
    lower_ctrl     = '0;
    upper_ctrl     = '0;
    lower_ctrl.clr = cfg_clr;
    upper_ctrl.clr = cfg_clr;
    lower_ctrl.rd  = (state_q == S_READ);
    upper_ctrl.rd  = (state_q == S_READ);
    lower_ctrl.wr  = (state_q == S_ACC) && (pass_q == PASS_LOWER);
    upper_ctrl.wr  = (state_q == S_ACC) && (pass_q == PASS_UPPER);
  end

  cobf_store #(
    .Depth (MAX_STAGES),
    .AddrW (AddrW)
  ) u_lower_store (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (lower_ctrl),
    .addr_i  (addr),
    .wdata_i (s_new),
    .rdata_o (lower_rdata)
  );

  cobf_store #(
    .Depth (MAX_STAGES),
    .AddrW (AddrW)
  ) u_upper_store (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (upper_ctrl),
    .addr_i  (addr),
    .wdata_i (s_new),
    .rdata_o (upper_rdata)
  );

  // Shared pole arithmetic.
  assign s_sel    = (pass_q == PASS_UPPER) ? upper_rdata : lower_rdata;
  assign pole_sel = (pass_q == PASS_UPPER) ? upper_pole_q : lower_pole_q;

  cobf_pole_unit u_pole (
    .clk_i    (clk_i),
    .mul_en_i (state_q == S_MUL),
    .pole_i   (pole_sel),
    .x_i      (v_q),
    .s_i      (s_sel),
    .s_new_o  (s_new)
  );

  // Highpass output x - s, saturated to 32 bits.
  assign hp_diff = {v_q[DATA_W-1], v_q} - {s_new[DATA_W-1], s_new};
  always_comb begin
    if (hp_diff[DATA_W] == hp_diff[DATA_W-1]) begin
      hp_sat = hp_diff[DATA_W-1:0];
    end else if (hp_diff[DATA_W]) begin
      hp_sat = {1'b1, {(DATA_W-1){1'b0}}};
    end else begin
      hp_sat = {1'b0, {(DATA_W-1){1'b1}}};
    end
  end

  // Drop the guard bits with rounding, then saturate to the sample range.
  assign rounded = {v_q[DATA_W-1], v_q} + (33'sd1 <<< (GUARD_W - 1));
  assign y_wide  = rounded[DATA_W:GUARD_W];
  always_comb begin
    if (y_wide[SAMPLE_W] == y_wide[SAMPLE_W-1]) begin
      y_sat = y_wide[SAMPLE_W-1:0];
    end else if (y_wide[SAMPLE_W]) begin
      y_sat = {1'b1, {(SAMPLE_W-1){1'b0}}};
    end else begin
      y_sat = {1'b0, {(SAMPLE_W-1){1'b1}}};
    end
  end

  // Stage sequencer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      pass_q      <= PASS_LOWER;
      band_q      <= 1'b0;
      high_q      <= 1'b0;
      k_q         <= '0;
      n_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      // A taken result is dropped unless the finish step replaces it.
      if (out_valid_q && !out_stall_i && state_q != S_FIN) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_accept) begin
            band_q  <= mode_band;
            high_q  <= mode_high;
            k_q     <= '0;
            n_q     <= n_eff;
            state_q <= (n_eff == '0) ? S_FIN : S_READ;
          end
        end
        S_READ: begin
          pass_q  <= (band_q || high_q) ? PASS_LOWER : PASS_UPPER;
          state_q <= S_MUL;
        end
        S_MUL: begin
          state_q <= S_ACC;
        end
        S_ACC: begin
          if (pass_q == PASS_LOWER && band_q) begin
            pass_q  <= PASS_UPPER;
            state_q <= S_MUL;
          end else begin
            k_q     <= k_next;
            state_q <= (k_next == n_q) ? S_FIN : S_READ;
          end
        end
        S_FIN: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // Signal path registers.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      v_q <= {sample_in_i, {GUARD_W{1'b0}}};
    end else if (state_q == S_ACC) begin
      v_q <= (pass_q == PASS_LOWER) ? hp_sat : s_new;
    end
    if (state_q == S_FIN && out_free) begin
      sample_out_q <= y_sat;
    end
  end

  // A new result appears only when the sequencer finishes an item.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q) == S_FIN)
    else $error("result raised outside the finish step");

  // The stage index stays inside the clamped count while stages run.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_READ || state_q == S_MUL || state_q == S_ACC) |-> k_q < n_q)
    else $error("stage index beyond stage count");

  // The upper pass only occurs in band or lowpass operation.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ACC && pass_q == PASS_UPPER) |-> (band_q || !high_q))
    else $error("upper store written in highpass mode");

endmodule

/* sv/cobf_store.sv */
module cobf_store import cobf_pkg::*; #(
  parameter int Depth = MAX_STAGES_DEF,
  parameter int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  store_ctrl_t              ctrl_i,
  input  logic [AddrW-1:0]         addr_i,
  input  logic signed [DATA_W-1:0] wdata_i,
  output logic signed [DATA_W-1:0] rdata_o
);

  logic signed [DATA_W-1:0] mem_q [Depth];
  logic [Depth-1:0]         valid_q;
  logic signed [DATA_W-1:0] rdata_q;
  logic                     rvalid_q;

  // Storage array with a registered read port.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.wr) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (ctrl_i.rd) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  // Entries that have not been written since the last clear read as zero.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rvalid_q <= 1'b0;
    end else begin
      if (ctrl_i.clr) begin
        valid_q <= '0;
      end else if (ctrl_i.wr) begin
        valid_q[addr_i] <= 1'b1;
      end
      if (ctrl_i.rd) begin
        rvalid_q <= valid_q[addr_i];
      end
    end
  end

  assign rdata_o = rvalid_q ? rdata_q : '0;

endmodule

/* sv/cobf_pole_unit.sv */
module cobf_pole_unit import cobf_pkg::*; (
  input  logic                     clk_i,
  input  logic                     mul_en_i,
  input  logic [POLE_W-1:0]        pole_i,
  input  logic signed [DATA_W-1:0] x_i,
  input  logic signed [DATA_W-1:0] s_i,
  output logic signed [DATA_W-1:0] s_new_o
);

  localparam int DiffW = DATA_W + 1;
  localparam int ProdW = DiffW + POLE_W + 1;
  localparam int AccW  = ProdW + 1;
  localparam int ShW   = AccW - POLE_W;

  logic signed [DiffW-1:0] diff;
  logic signed [ProdW-1:0] prod_q;
  logic signed [AccW-1:0]  acc;
  logic signed [ShW-1:0]   shifted;

  // Registered product: c * (s - x), which with x * 2^16 gives (1-c)*x + c*s.
  assign diff = {s_i[DATA_W-1], s_i} - {x_i[DATA_W-1], x_i};

  always_ff @(posedge clk_i) begin
    if (mul_en_i) begin
      prod_q <= $signed({1'b0, pole_i}) * diff;
    end
  end

  // From the product register: add x * 2^16 and the rounding half, floor shift, saturate.
  assign acc = {{(AccW-DATA_W-POLE_W){x_i[DATA_W-1]}}, x_i, {POLE_W{1'b0}}}
             + {prod_q[ProdW-1], prod_q}
             + (AccW'(1) <<< (POLE_W - 1));
  assign shifted = acc[AccW-1:POLE_W];

  always_comb begin
    if (shifted[ShW-1:DATA_W-1] == {(ShW-DATA_W+1){1'b0}} ||
        shifted[ShW-1:DATA_W-1] == {(ShW-DATA_W+1){1'b1}}) begin
      s_new_o = shifted[DATA_W-1:0];
    end else if (shifted[ShW-1]) begin
      s_new_o = {1'b1, {(DATA_W-1){1'b0}}};
    end else begin
      s_new_o = {1'b0, {(DATA_W-1){1'b1}}};
    end
  end

endmodule

/* test/testbench.sv */
`timescale 1ns / 100ps

module testbench;
  import cobf_pkg::*;

  localparam int STAGES = MAX_STAGES_DEF;
  // Longest latency (band mode, every stage) plus some margin.
  localparam int IDLE_CYCLES = 2 + 5 * STAGES + 8;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int RANDOM_ITEMS = 1900;
  localparam int DIRECTED_ROWS = 39;
  localparam logic signed [SAMPLE_W-1:0] SMP_MAX = 24'sh7FFFFF;
  localparam logic signed [SAMPLE_W-1:0] SMP_MIN = 24'sh800000;
  localparam longint OUT_HI = 64'sd8388607;
  localparam longint OUT_LO = -64'sd8388608;
  localparam longint WORD_HI = 64'sd2147483647;
  localparam longint WORD_LO = -64'sd2147483648;

  // One row of the directed part: a register write or a sample, with an
  // optional typed-in result.
  typedef struct packed {
    logic                       wr;
    logic [CFG_IDX_W-1:0]       idx;
    logic [CFG_DATA_W-1:0]      wdata;
    logic signed [SAMPLE_W-1:0] smp;
    logic                       typed;
    logic signed [SAMPLE_W-1:0] want;
  } plan_row_t;

  logic                       clk_i = 1'b0;
  logic                       rst_ni = 1'b0;
  logic                       in_valid_i = 1'b0;
  logic                       in_stall_o;
  logic signed [SAMPLE_W-1:0] sample_in_i = '0;
  logic                       out_valid_o;
  logic                       out_stall_i = 1'b0;
  logic signed [SAMPLE_W-1:0] sample_out_o;
  logic                       cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]       cfg_index_i = '0;
  logic [CFG_DATA_W-1:0]      cfg_wdata_i = '0;

  // Filter registers and stage states as the block should hold them.
  logic [MODE_W-1:0]          cur_mode = MODE_RST;
  logic [COUNT_W-1:0]         cur_stages = STAGE_COUNT_RST;
  logic [POLE_W-1:0]          cur_upper = POLE_RST;
  logic [POLE_W-1:0]          cur_lower = POLE_RST;
  logic signed [DATA_W-1:0]   upper_state [STAGES] = '{default: '0};
  logic signed [DATA_W-1:0]   lower_state [STAGES] = '{default: '0};

  logic signed [SAMPLE_W-1:0] expected_out [$];
  int                         mismatch_count = 0;
  int                         cycle_count = 0;
  int                         tx_gap_max = 4;
  int                         rx_hold_max = 4;
  int                         hold_left = 0;
  bit                         cfg_open = 1'b0;

  plan_row_t plan [DIRECTED_ROWS] = '{
    // Reset defaults: band mode with both poles at zero gives silence.
    '{1'b0, CFG_MODE, 16'd0, SMP_MAX, 1'b1, 24'sd0},
    '{1'b0, CFG_MODE, 16'd0, SMP_MIN, 1'b1, 24'sd0},
    '{1'b0, CFG_MODE, 16'd0, 24'sd0, 1'b1, 24'sd0},
    // Lowpass with a zero pole passes the sample through.
    '{1'b1, CFG_MODE, 16'(MODE_LOWPASS), 24'sd0, 1'b0, 24'sd0},
    '{1'b0, CFG_MODE, 16'd0, SMP_MAX, 1'b1, SMP_MAX},
    '{1'b0, CFG_MODE, 16'd0, SMP_MIN, 1'b1, SMP_MIN},
    // A stage count above the maximum is clamped.
    '{1'b1, CFG_STAGE_COUNT, 16'd15, 24'sd0, 1'b0, 24'sd0},
    '{1'b0, CFG_MODE, 16'd0, 24'sh5A5A5A, 1'b1, 24'sh5A5A5A},
    // Highpass with a zero pole removes everything.
    '{1'b1, CFG_MODE, 16'(MODE_HIGHPASS), 24'sd0, 1'b0, 24'sd0},
    '{1'b0, CFG_MODE, 16'd0, 24'sh12D687, 1'b1, 24'sd0},
    // With no stages the sample comes out unchanged.
    '{1'b1, CFG_STAGE_COUNT, 16'd0, 24'sd0, 1'b0, 24'sd0},
    '{1'b0, CFG_MODE, 16'd0, 24'shFFFFFF, 1'b1, 24'shFFFFFF},
    '{1'b0, CFG_MODE, 16'd0, SMP_MAX, 1'b1, SMP_MAX},
    // The unused mode code acts as band mode; all stages, extreme poles.
    '{1'b1, CFG_MODE, 16'(MODE_BAND | MODE_HIGHPASS), 24'sd0, 1'b0, 24'sd0},
    '{1'b1, CFG_STAGE_COUNT, 16'd8, 24'sd0, 1'b0, 24'sd0},
    '{1'b1, CFG_UPPER_POLE, 16'hFFFF, 24'sd0, 1'b0, 24'sd0},
    '{1'b1, CFG_LOWER_POLE, 16'hFFFF, 24'sd0, 1'b0, 24'sd0},
    '{1'b0, CFG_MODE, 16'd0, SMP_MAX, 1'b0, 24'sd0},
    '{1'b0, CFG_MODE, 16'd0, SMP_MIN, 1'b0, 24'sd0},
    '{1'b0, CFG_MODE, 16'd0, SMP_MAX, 1'b0, 24'sd0},
    '{1'b0, CFG_MODE, 16'd0, 24'sd1, 1'b0, 24'sd0},
    '{1'b1, CFG_MODE, 16'(MODE_HIGHPASS), 24'sd0, 1'b0, 24'sd0},
    '{1'b0, CFG_MODE, 16'd0, SMP_MAX, 1'b0, 24'sd0},
    '{1'b0, CFG_MODE, 16'd0, SMP_MIN, 1'b0, 24'sd0},
    // Full-scale swings through a mid pole in highpass mode.
    '{1'b1, CFG_STAGE_COUNT, 16'd1, 24'sd0, 1'b0, 24'sd0},
    '{1'b1, CFG_LOWER_POLE, 16'h8000, 24'sd0, 1'b0, 24'sd0},
    '{1'b0, CFG_MODE, 16'd0, SMP_MIN, 1'b0, 24'sd0},
    '{1'b0, CFG_MODE, 16'd0, SMP_MAX, 1'b0, 24'sd0},
    '{1'b0, CFG_MODE, 16'd0, SMP_MIN, 1'b0, 24'sd0},
    '{1'b1, CFG_MODE, 16'(MODE_LOWPASS), 24'sd0, 1'b0, 24'sd0},
    '{1'b1, CFG_STAGE_COUNT, 16'd2, 24'sd0, 1'b0, 24'sd0},
    '{1'b1, CFG_UPPER_POLE, 16'h8000, 24'sd0, 1'b0, 24'sd0},
    '{1'b0, CFG_MODE, 16'd0, SMP_MAX, 1'b0, 24'sd0},
    '{1'b0, CFG_MODE, 16'd0, 24'sd3, 1'b0, 24'sd0},
    '{1'b1, CFG_MODE, 16'(MODE_BAND), 24'sd0, 1'b0, 24'sd0},
    '{1'b1, CFG_UPPER_POLE, 16'h4000, 24'sd0, 1'b0, 24'sd0},
    '{1'b1, CFG_LOWER_POLE, 16'hF000, 24'sd0, 1'b0, 24'sd0},
    '{1'b0, CFG_MODE, 16'd0, 24'sh400000, 1'b0, 24'sd0},
    '{1'b0, CFG_MODE, 16'd0, 24'shC00000, 1'b0, 24'sd0}
  };

  cascaded_one_pole_band_filter dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .sample_in_i (sample_in_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sample_out_o(sample_out_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // Run limit.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic logic signed [DATA_W-1:0] clamp32(input longint val);
    if (val > WORD_HI) return DATA_W'(WORD_HI);
    if (val < WORD_LO) return DATA_W'(WORD_LO);
    return DATA_W'(val);
  endfunction

  // One-pole smoothing step with rounding: (1-c)*x + c*s, c in Q0.16.
  function automatic logic signed [DATA_W-1:0] smooth(input logic signed [DATA_W-1:0] x,
                                                      input logic signed [DATA_W-1:0] s,
                                                      input logic [POLE_W-1:0] c);
    longint acc;
    acc = (64'sd65536 - longint'(c)) * longint'(x) + longint'(c) * longint'(s) + 64'sd32768;
    return clamp32(acc >>> 16);
  endfunction

  // Runs one sample through the cascade, updating the stage states.
  function automatic logic signed [SAMPLE_W-1:0] filter_sample(
      input logic signed [SAMPLE_W-1:0] smp);
    logic signed [DATA_W-1:0] v;
    logic signed [DATA_W-1:0] s;
    longint y;
    int n;
    bit band;
    bit high;
    bit low;
    band = (cur_mode & MODE_BAND) != '0;
    high = !band && (cur_mode == MODE_HIGHPASS);
    low = !band && !high;
    v = {smp, {GUARD_W{1'b0}}};
    n = (cur_stages > STAGES) ? STAGES : int'(cur_stages);
    for (int k = 0; k < n; k++) begin
      if (band || high) begin
        s = smooth(v, lower_state[k], cur_lower);
        lower_state[k] = s;
        v = clamp32(longint'(v) - longint'(s));
      end
      if (band || low) begin
        s = smooth(v, upper_state[k], cur_upper);
        upper_state[k] = s;
        v = s;
      end
    end
    y = (longint'(v) + 64'sd128) >>> GUARD_W;
    if (y > OUT_HI) y = OUT_HI;
    if (y < OUT_LO) y = OUT_LO;
    return SAMPLE_W'(y);
  endfunction

  function automatic logic [POLE_W-1:0] draw_pole();
    case ($urandom_range(0, 4))
      0: return '0;
      1: return '1;
      2: return POLE_W'($urandom_range(60000, 65535));
      default: return POLE_W'($urandom);
    endcase
  endfunction

  // Sample mix: extremes, small values, slow drift around the last value, and full range.
  function automatic logic signed [SAMPLE_W-1:0] draw_sample(
      input logic signed [SAMPLE_W-1:0] last);
    case ($urandom_range(0, 9))
      0: return SMP_MAX;
      1: return SMP_MIN;
      2: return SAMPLE_W'($urandom_range(0, 512)) - 24'sd256;
      3, 4: return last + SAMPLE_W'($urandom_range(0, 64)) - 24'sd32;
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  function automatic int draw_idle_max();
    case ($urandom_range(0, 2))
      0: return 0;
      1: return 3;
      default: return 16;
    endcase
  endfunction

  // Drops valid and waits until every expected sample has come back.
  task automatic settle();
    in_valid_i <= 1'b0;
    while (expected_out.size() > 0) @(posedge clk_i);
    repeat (IDLE_CYCLES) @(posedge clk_i);
  endtask

  // Register write; the first write of a batch waits for the block to go idle.
  task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    if (!cfg_open) settle();
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    case (idx)
      CFG_MODE:        cur_mode = data[MODE_W-1:0];
      CFG_STAGE_COUNT: cur_stages = data[COUNT_W-1:0];
      CFG_UPPER_POLE:  cur_upper = data[POLE_W-1:0];
      CFG_LOWER_POLE:  cur_lower = data[POLE_W-1:0];
      default: ;
    endcase
    // Any register write clears both stage stores.
    upper_state = '{default: '0};
    lower_state = '{default: '0};
    cfg_open = 1'b1;
  endtask

  // Offers one sample transaction after a random gap and records its expected result.
  task automatic send_sample(input logic signed [SAMPLE_W-1:0] smp, input bit typed,
                             input logic signed [SAMPLE_W-1:0] want);
    int gap;
    logic signed [SAMPLE_W-1:0] predicted;
    gap = $urandom_range(0, tx_gap_max);
    if (cfg_open) begin
      cfg_we_i <= 1'b0;
      cfg_open = 1'b0;
    end
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    sample_in_i <= smp;
    do @(posedge clk_i); while (in_stall_o);
    predicted = filter_sample(smp);
    expected_out.push_back(typed ? want : predicted);
  endtask

  // Output side: random stall after each transaction, checking against the oldest expectation.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      hold_left = 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_out.size() == 0) begin
          $error("sample_out: unexpected transaction, actual %0d", sample_out_o);
          mismatch_count++;
        end else if (sample_out_o !== expected_out[0]) begin
          $error("sample_out: expected %0d, actual %0d", expected_out[0], sample_out_o);
          mismatch_count++;
          void'(expected_out.pop_front());
        end else begin
          void'(expected_out.pop_front());
        end
        hold_left = $urandom_range(0, rx_hold_max);
      end else if (hold_left > 0) begin
        hold_left--;
      end
      out_stall_i <= (hold_left > 0);
    end
  end

  // Stimulus: directed rows, then random phases, each with a new mode and, by chance, a new stage count and poles.
  initial begin
    int items_sent;
    int phase_len;
    logic [CFG_DATA_W-1:0] wdata;
    logic signed [SAMPLE_W-1:0] smp;
    items_sent = 0;
    smp = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan[i]) begin
      if (plan[i].wr) begin
        put_reg(plan[i].idx, plan[i].wdata);
      end else begin
        send_sample(plan[i].smp, plan[i].typed, plan[i].want);
      end
    end

    while (items_sent < RANDOM_ITEMS) begin
      tx_gap_max = draw_idle_max();
      rx_hold_max = draw_idle_max();
      // Unused upper bits of the narrow registers carry random values.
      wdata = CFG_DATA_W'($urandom);
      put_reg(CFG_MODE, wdata);
      if ($urandom_range(0, 3) != 0) begin
        wdata = CFG_DATA_W'($urandom);
        put_reg(CFG_STAGE_COUNT, wdata);
      end
      if ($urandom_range(0, 3) != 0) put_reg(CFG_UPPER_POLE, draw_pole());
      if ($urandom_range(0, 3) != 0) put_reg(CFG_LOWER_POLE, draw_pole());
      phase_len = $urandom_range(30, 110);
      repeat (phase_len) begin
        smp = draw_sample(smp);
        send_sample(smp, 1'b0, '0);
        items_sent++;
      end
    end

    settle();
    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
